// ===== src/zsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// zsmd_pkg
// Shared types and constants of the zero-skew merge distance block.
// ----------------------------------------------------------------------------
package zsmd_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUO_W         = 32;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP = 1'b1;

  typedef enum logic [1:0] {
    SPLIT_WITHIN = 2'd0,
    SPLIT_EXT_B  = 2'd1,
    SPLIT_EXT_A  = 2'd2
  } split_t;

  // operands of one item while the front multipliers work
  typedef struct packed {
    logic [DATA_W-1:0] ca;
    logic [DATA_W-1:0] da;
    logic [DATA_W-1:0] cb;
    logic [DATA_W-1:0] db;
    logic [DATA_W-1:0] len;
  } op_t;

  // per-item sideband carried from the case decision to the output
  typedef struct packed {
    split_t              kase;
    logic                dz;
    logic                sat;
    logic [DATA_W-1:0]   len;
    logic [DATA_W-1:0]   x;
    logic [2*DATA_W-1:0] kr;
  } side_t;

endpackage

// ===== src/zero_skew_merge_distance.sv =====
// ----------------------------------------------------------------------------
// zero_skew_merge_distance
// Elmore zero-skew merge split of two subtrees, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the output side holds the pipe full, and
// returns one beat per input beat, in order. Most of the depth is the square
// root (one root bit per stage) followed by a 32-stage divider; the
// within-wire divider runs alongside it. Every stage holds a valid bit and a
// stage that is empty refills even while the output waits, so bubbles close
// up under back pressure and new beats keep coming in until the pipe is full.
// Write the per-unit registers only while no beat is in flight; a zero
// register acts as the smallest legal value.
// ----------------------------------------------------------------------------
module zero_skew_merge_distance import zsmd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_load_cap_a,
  input  logic [DATA_W-1:0]    in_delay_a,
  input  logic [DATA_W-1:0]    in_load_cap_b,
  input  logic [DATA_W-1:0]    in_delay_b,
  input  logic [DATA_W-1:0]    in_wire_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_dist_from_a,
  output logic [DATA_W-1:0]    out_dist_from_b,
  output logic [1:0]           out_split_case,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int F = FRAC_BITS;

  // widths of the split terms
  localparam int DENW = (((66 + 2*F) > (97 + F)) ? (66 + 2*F) : (97 + F)) + 1;
  localparam int PPW  = (((33 + 3*F) > (97 + F)) ? (33 + 3*F) : (97 + F)) + 1;
  localparam int POSW = ((PPW > 128) ? PPW : 128) + 1;
  localparam int NUMW = POSW + F;
  localparam int NDL  = (DENW + 31) / 32;
  localparam int DLPW = NDL * 32;
  localparam int LIMW = DLPW + 32;
  localparam int CMW  = (NUMW > LIMW) ? NUMW : LIMW;
  // widths of the branch extension
  localparam int QW   = ((96 > 65 + F) ? 96 : 65 + F) + 1;
  localparam int NQL  = (QW + 31) / 32;
  localparam int QPW  = NQL * 32;
  localparam int RW   = QW + 32 + 2*F;
  localparam int SW   = (RW + 1) / 2;
  localparam int RW2  = 2 * SW;
  localparam int KRW  = 64 + F;
  localparam int SPC  = (SW > KRW) ? SW : KRW;
  localparam int SATW = (SW > 96) ? SW : 96;

  // stage map
  localparam int S_CASE = 7;
  localparam int WD0    = 8;
  localparam int WXI    = WD0 + QUO_W;
  localparam int S_E1   = 8;
  localparam int SQ0    = 13;
  localparam int S_SUB  = SQ0 + SW;
  localparam int S_SAT  = S_SUB + 1;
  localparam int ED0    = S_SAT + 1;
  localparam int S_OUT  = ED0 + QUO_W;
  localparam int NST    = S_OUT + 1;

  // ---------------------------------------------------------------- config
  logic [DATA_W-1:0]   res_r, cap_r;
  logic [DATA_W-1:0]   r_eff, c_eff;
  logic [2*DATA_W-1:0] rc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= DATA_W'(1) << F;
      cap_r <= DATA_W'(1) << F;
    end else if (cfg_valid) begin
      priority if (cfg_index == CFG_RES) begin
        res_r <= cfg_data;
      end else if (cfg_index == CFG_CAP) begin
        cap_r <= cfg_data;
      end
    end
  end

  // a zero register counts as the smallest legal value
  assign r_eff = (res_r == '0) ? DATA_W'(1) : res_r;
  assign c_eff = (cap_r == '0) ? DATA_W'(1) : cap_r;

  // r*c settles in the cycle after a write, before any beat reaches stage 1
  always_ff @(posedge clk) begin
    rc_r <= 64'(r_eff) * 64'(c_eff);
  end

  // ---------------------------------------------------- stage flow control
  // A stage loads when the pipe advances or when it is empty; an item that
  // moves on without a replacement leaves a bubble behind.
  logic [NST-1:0] v_r, v_nxt, ld, ld_up, vsrc;
  logic           adv;

  assign adv      = out_ready | ~v_r[NST-1];
  assign ld       = {NST{adv}} | ~v_r;
  assign ld_up    = {out_ready, ld[NST-1:1]};
  assign vsrc     = {v_r[NST-2:0], in_valid};
  assign v_nxt    = (ld & vsrc) | (~ld & ~ld_up & v_r);
  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // ------------------------------------------------------ operand carrier
  op_t opd_r [0:S_CASE-1];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      opd_r[0] <= '{ca: in_load_cap_a, da: in_delay_a, cb: in_load_cap_b,
                    db: in_delay_b, len: in_wire_length};
    end
  end

  for (genvar i = 1; i < S_CASE; i++) begin : g_opd
    always_ff @(posedge clk) begin
      if (ld[i]) begin
        opd_r[i] <= opd_r[i-1];
      end
    end
  end

  // ------------------------------------------------ split numerator terms
  logic [63:0]     rl1_r;
  logic [63:0]     rcl1_r [2];
  logic [32:0]     sab1_r;
  logic [95:0]     b2_r;
  logic [63:0]     acb2_r [2];
  logic [64:0]     sabr2_r;
  logic [95:0]     t1_3_r, b3_r;
  logic [63:0]     bl3_r [3];
  logic [64:0]     sabr3_r;
  logic [127:0]    t2_4_r;
  logic [DENW-1:0] den4_r, den5_r, den6_r, den7_r;
  logic [PPW-1:0]  pp4_r;
  logic [POSW-1:0] pos5_r;
  logic [63:0]     dl5_r [NDL];
  logic [POSW:0]   diff6_r;
  logic [LIMW-1:0] lim6_r;
  logic [NUMW-1:0] num7_r;
  logic [DATA_W-1:0] k7_r, dd7_r;

  logic [127:0]    t2_sum;
  logic [LIMW-1:0] lim_sum;
  logic [DLPW-1:0] den4_pad;

  // stage 1: first products
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      rl1_r     <= 64'(r_eff) * 64'(opd_r[0].len);
      rcl1_r[0] <= 64'(rc_r[31:0]) * 64'(opd_r[0].len);
      rcl1_r[1] <= 64'(rc_r[63:32]) * 64'(opd_r[0].len);
      sab1_r    <= 33'(opd_r[0].ca) + 33'(opd_r[0].cb);
    end
  end

  // stage 2: r*c*L, r*L*Cb partials, (Ca+Cb)*r
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      b2_r      <= 96'(rcl1_r[0]) + (96'(rcl1_r[1]) << 32);
      acb2_r[0] <= 64'(rl1_r[31:0]) * 64'(opd_r[1].cb);
      acb2_r[1] <= 64'(rl1_r[63:32]) * 64'(opd_r[1].cb);
      sabr2_r   <= 65'(sab1_r) * 65'(r_eff);
    end
  end

  // stage 3: r*L*Cb, r*c*L*L partials
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      t1_3_r  <= 96'(acb2_r[0]) + (96'(acb2_r[1]) << 32);
      for (int m = 0; m < 3; m++) begin
        bl3_r[m] <= 64'(b2_r[32*m +: 32]) * 64'(opd_r[2].len);
      end
      sabr3_r <= sabr2_r;
      b3_r    <= b2_r;
    end
  end

  always_comb begin
    t2_sum = '0;
    for (int m = 0; m < 3; m++) begin
      t2_sum = t2_sum + (128'(bl3_r[m]) << (32*m));
    end
  end

  // stage 4: denominator and first part of the numerator
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      t2_4_r <= t2_sum;
      den4_r <= (DENW'(sabr3_r) << (2*F + 1)) + (DENW'(b3_r) << (F + 1));
      pp4_r  <= (PPW'(opd_r[3].db) << (3*F + 1)) + (PPW'(t1_3_r) << (F + 1));
    end
  end

  assign den4_pad = DLPW'(den4_r);

  // stage 5: full numerator, den*L partials
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      pos5_r <= POSW'(pp4_r) + POSW'(t2_4_r);
      for (int m = 0; m < NDL; m++) begin
        dl5_r[m] <= 64'(den4_pad[32*m +: 32]) * 64'(opd_r[4].len);
      end
      den5_r <= den4_r;
    end
  end

  always_comb begin
    lim_sum = '0;
    for (int m = 0; m < NDL; m++) begin
      lim_sum = lim_sum + (LIMW'(dl5_r[m]) << (32*m));
    end
  end

  // stage 6: signed numerator and the upper limit den*L
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      diff6_r <= {1'b0, pos5_r} - ((POSW + 1)'(opd_r[5].da) << (3*F + 1));
      lim6_r  <= lim_sum;
      den6_r  <= den5_r;
    end
  end

  // stage 7: decide the case and pick the branch to extend
  logic            c1, c2;
  logic [NUMW-1:0] num_v;
  split_t          kase_v;

  assign c1    = diff6_r[POSW];
  assign num_v = NUMW'(diff6_r[POSW-1:0]) << F;
  assign c2    = !c1 && (CMW'(num_v) > CMW'(lim6_r));

  always_comb begin
    priority if (c1) begin
      kase_v = SPLIT_EXT_B;
    end else if (c2) begin
      kase_v = SPLIT_EXT_A;
    end else begin
      kase_v = SPLIT_WITHIN;
    end
  end

  side_t side_r [S_CASE:S_OUT-1];

  always_ff @(posedge clk) begin
    if (ld[S_CASE]) begin
      num7_r <= num_v;
      den7_r <= den6_r;
      if (c1) begin
        k7_r  <= opd_r[6].cb;
        dd7_r <= (opd_r[6].da >= opd_r[6].db) ? opd_r[6].da - opd_r[6].db : '0;
      end else begin
        k7_r  <= opd_r[6].ca;
        dd7_r <= (opd_r[6].db >= opd_r[6].da) ? opd_r[6].db - opd_r[6].da : '0;
      end
      side_r[S_CASE] <= '{kase: kase_v, dz: (den6_r == '0), sat: 1'b0,
                          len: opd_r[6].len, x: '0, kr: '0};
    end
  end

  // ------------------------------------------------- within-wire divider
  logic [QUO_W-1:0] wq;

  zsmd_div_pipe #(
    .NUM_W (NUMW),
    .DEN_W (DENW),
    .Q_W   (QUO_W)
  ) u_div_within (
    .clk    (clk),
    .ld     (ld[WD0 +: QUO_W]),
    .num_in (num7_r),
    .den_in (den7_r),
    .quo    (wq)
  );

  // ----------------------------------------------------- branch extension
  logic [63:0]    kk8_r, ddc8_r;
  logic [63:0]    kkr9_r [2];
  logic [63:0]    ddc9_r;
  logic [QW-1:0]  q10_r;
  logic [QPW-1:0] q10_pad;
  logic [63:0]    qr11_r [NQL];
  logic [RW-1:0]  rad12_r;
  logic [QPW+31:0] qr_sum;
  logic [63:0]    kr_v;

  assign kr_v = 64'(k7_r) * 64'(r_eff);

  // stage 8: k*k, k*r, dd*c
  always_ff @(posedge clk) begin
    if (ld[S_E1]) begin
      kk8_r  <= 64'(k7_r) * 64'(k7_r);
      ddc8_r <= 64'(dd7_r) * 64'(c_eff);
    end
  end

  // stage 9: k*k*r partials
  always_ff @(posedge clk) begin
    if (ld[S_E1+1]) begin
      kkr9_r[0] <= 64'(kk8_r[31:0]) * 64'(r_eff);
      kkr9_r[1] <= 64'(kk8_r[63:32]) * 64'(r_eff);
      ddc9_r    <= ddc8_r;
    end
  end

  // stage 10: Q = k*k*r + dd*c*2^(F+1)
  always_ff @(posedge clk) begin
    if (ld[S_E1+2]) begin
      q10_r <= QW'(kkr9_r[0]) + (QW'(kkr9_r[1]) << 32) + (QW'(ddc9_r) << (F + 1));
    end
  end

  assign q10_pad = QPW'(q10_r);

  // stage 11: Q*r partials
  always_ff @(posedge clk) begin
    if (ld[S_E1+3]) begin
      for (int m = 0; m < NQL; m++) begin
        qr11_r[m] <= 64'(q10_pad[32*m +: 32]) * 64'(r_eff);
      end
    end
  end

  always_comb begin
    qr_sum = '0;
    for (int m = 0; m < NQL; m++) begin
      qr_sum = qr_sum + ((QPW + 32)'(qr11_r[m]) << (32*m));
    end
  end

  // stage 12: radicand Q*r*2^(2F)
  always_ff @(posedge clk) begin
    if (ld[S_E1+4]) begin
      rad12_r <= RW'(qr_sum[QW+31:0]) << (2*F);
    end
  end

  // square root, one root bit per stage from the top
  logic [RW2-1:0] sq_rem_r [SW];
  logic [SW-1:0]  sq_q_r   [SW];

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    localparam int B = SW - 1 - j;
    logic [RW2-1:0] rem_src, trial;
    logic [SW-1:0]  q_src;

    if (j == 0) begin : g_first
      assign rem_src = RW2'(rad12_r);
      assign q_src   = '0;
    end else begin : g_next
      assign rem_src = sq_rem_r[j-1];
      assign q_src   = sq_q_r[j-1];
    end

    // (q + 2^B)^2 - q^2
    assign trial = (RW2'(q_src) << (B + 1)) | (RW2'(1) << (2*B));

    always_ff @(posedge clk) begin
      if (ld[SQ0+j]) begin
        if (rem_src >= trial) begin
          sq_rem_r[j] <= rem_src - trial;
          sq_q_r[j]   <= q_src | (SW'(1) << B);
        end else begin
          sq_rem_r[j] <= rem_src;
          sq_q_r[j]   <= q_src;
        end
      end
    end
  end

  // subtract k*r*2^F, clamp at zero
  logic [SW-1:0]  sp_r, sp2_r;
  logic [SPC-1:0] root_x, krs;
  logic           sat_v;

  assign root_x = SPC'(sq_q_r[SW-1]);
  assign krs    = SPC'(side_r[S_SUB-1].kr) << F;

  always_ff @(posedge clk) begin
    if (ld[S_SUB]) begin
      sp_r <= (root_x >= krs) ? SW'(root_x - krs) : '0;
    end
  end

  // quotient would not fit in 32 bits
  assign sat_v = SATW'(sp_r) >= (SATW'(rc_r) << 32);

  always_ff @(posedge clk) begin
    if (ld[S_SAT]) begin
      sp2_r <= sp_r;
    end
  end

  logic [QUO_W-1:0] eq;

  zsmd_div_pipe #(
    .NUM_W (SW),
    .DEN_W (64),
    .Q_W   (QUO_W)
  ) u_div_ext (
    .clk    (clk),
    .ld     (ld[ED0 +: QUO_W]),
    .num_in (sp2_r),
    .den_in (rc_r),
    .quo    (eq)
  );

  // ------------------------------------------------------ sideband line
  for (genvar i = S_CASE + 1; i < S_OUT; i++) begin : g_side
    side_t side_nxt;

    always_comb begin
      side_nxt = side_r[i-1];
      if (i == S_E1) begin
        side_nxt.kr = kr_v;
      end
      if (i == WXI) begin
        // zero denominator means both distances are zero
        side_nxt.x = side_r[i-1].dz ? '0 : wq;
      end
      if (i == S_SAT) begin
        side_nxt.sat = sat_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[i]) begin
        side_r[i] <= side_nxt;
      end
    end
  end

  // ---------------------------------------------------------- output beat
  logic [DATA_W-1:0] dist_a_r, dist_b_r;
  split_t            kase_r;
  logic              sat_r;
  side_t             so;
  logic [DATA_W-1:0] ext_v;

  assign so    = side_r[S_OUT-1];
  assign ext_v = so.sat ? '1 : eq;

  always_ff @(posedge clk) begin
    if (ld[S_OUT]) begin
      kase_r <= so.kase;
      unique case (so.kase)
        SPLIT_WITHIN: begin
          dist_a_r <= so.x;
          dist_b_r <= so.len - so.x;
          sat_r    <= 1'b0;
        end
        SPLIT_EXT_B: begin
          dist_a_r <= '0;
          dist_b_r <= ext_v;
          sat_r    <= so.sat;
        end
        SPLIT_EXT_A: begin
          dist_a_r <= ext_v;
          dist_b_r <= '0;
          sat_r    <= so.sat;
        end
        default: begin
          dist_a_r <= '0;
          dist_b_r <= '0;
          sat_r    <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid       = v_r[NST-1];
  assign out_dist_from_a = dist_a_r;
  assign out_dist_from_b = dist_b_r;
  assign out_split_case  = kase_r;
  assign out_saturated   = sat_r;

endmodule

// ===== src/zsmd_div_pipe.sv =====
// ----------------------------------------------------------------------------
// zsmd_div_pipe
// Restoring divider, one quotient bit per register stage, for quotients
// known to fit in Q_W bits.
// ----------------------------------------------------------------------------
module zsmd_div_pipe import zsmd_pkg::*; #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 64,
  parameter int Q_W   = QUO_W
) (
  input  logic             clk,
  input  logic [Q_W-1:0]   ld,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [Q_W-1:0]   quo
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CW-1:0]    rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [CW-1:0]    rem_src;
    logic [CW-1:0]    sub;
    logic [DEN_W-1:0] den_src;
    logic [Q_W-1:0]   q_src;

    if (s == 0) begin : g_first
      assign rem_src = CW'(num_in);
      assign den_src = den_in;
      assign q_src   = '0;
    end else begin : g_next
      assign rem_src = rem_r[s-1];
      assign den_src = den_r[s-1];
      assign q_src   = q_r[s-1];
    end

    assign sub = CW'(den_src) << B;

    always_ff @(posedge clk) begin
      if (ld[s]) begin
        den_r[s] <= den_src;
        if (rem_src >= sub) begin
          rem_r[s] <= rem_src - sub;
          q_r[s]   <= q_src | (Q_W'(1) << B);
        end else begin
          rem_r[s] <= rem_src;
          q_r[s]   <= q_src;
        end
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

// ===== src/zsmd_checker.sv =====
// ----------------------------------------------------------------------------
// zsmd_checker
// Port-level checks of the merge distance result channel.
// ----------------------------------------------------------------------------
module zsmd_checker import zsmd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_dist_from_a,
  input logic [DATA_W-1:0] out_dist_from_b,
  input logic [1:0]        out_split_case,
  input logic              out_saturated
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dist_from_a)
      && $stable(out_dist_from_b) && $stable(out_split_case)
      && $stable(out_saturated))
    else $error("result beat changed while stalled");

  a_within_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_split_case == SPLIT_WITHIN |-> !out_saturated)
    else $error("within-wire split flagged saturated");

  a_ext_b_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_split_case == SPLIT_EXT_B |-> out_dist_from_a == '0)
    else $error("second branch extended but first distance nonzero");

  a_ext_a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_split_case == SPLIT_EXT_A |-> out_dist_from_b == '0)
    else $error("first branch extended but second distance nonzero");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_split_case == SPLIT_EXT_B && out_dist_from_b == '1)
      || (out_split_case == SPLIT_EXT_A && out_dist_from_a == '1))
    else $error("saturated beat not clipped to maximum");

endmodule

bind zero_skew_merge_distance zsmd_checker u_zsmd_checker (.*);

// ===== bench/zero_skew_merge_distance_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zero_skew_merge_distance_tb
// Self-checking bench for the Elmore zero-skew merge split.
// ----------------------------------------------------------------------------
// A wide-integer model of the split runs beside the block. Each input beat
// accepted queues its expected split. Each result beat is checked against
// the oldest one in the queue. Both sides idle at random. One phase holds
// the result side off long enough to fill the pipe. Another phase drains
// the pipe mid-stream. The per-unit registers are changed between phases
// only while the pipe is empty.
// ----------------------------------------------------------------------------
module zero_skew_merge_distance_tb;
  import zsmd_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int PIPE_LAT  = 129;
  localparam int DRAIN_CYC = PIPE_LAT + 40;

  typedef struct {
    logic [DATA_W-1:0] dist_a;
    logic [DATA_W-1:0] dist_b;
    split_t            kase;
    logic              sat;
  } split_res_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [DATA_W-1:0] in_load_cap_a, in_delay_a, in_load_cap_b, in_delay_b, in_wire_length;
  logic out_valid, out_ready;
  logic [DATA_W-1:0] out_dist_from_a, out_dist_from_b;
  logic [1:0] out_split_case;
  logic out_saturated;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  zero_skew_merge_distance dut (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .in_load_cap_a, .in_delay_a, .in_load_cap_b, .in_delay_b, .in_wire_length,
    .out_valid, .out_ready,
    .out_dist_from_a, .out_dist_from_b, .out_split_case, .out_saturated,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // model copy of the per-unit registers
  logic [DATA_W-1:0] res_per_unit = 32'h0001_0000;
  logic [DATA_W-1:0] cap_per_unit = 32'h0001_0000;

  split_res_t split_q[$];
  int  mismatches = 0;
  bit  zero_gaps  = 0;      // burst mode: no idling on either side
  int  hold_ticket = 0;     // bump to request a long result-side hold
  int  hold_len    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of the square root of a wide value.
  function automatic bit [255:0] isqrt256(bit [255:0] n);
    bit [255:0] root, one_bit;
    root    = '0;
    one_bit = 256'd1 << 254;
    while (one_bit > n) one_bit = one_bit >> 2;
    while (one_bit != 0) begin
      if (n >= root + one_bit) begin
        n    = n - (root + one_bit);
        root = (root >> 1) + one_bit;
      end else begin
        root = root >> 1;
      end
      one_bit = one_bit >> 2;
    end
    return root;
  endfunction

  // Length of a stretched branch, clipped to 32 bits.
  function automatic logic [DATA_W-1:0] stretch_len(bit [255:0] k, bit [255:0] dhi,
                                                    bit [255:0] dlo, bit [255:0] r,
                                                    bit [255:0] c, output logic sat);
    bit [255:0] rad, root, ofs, q;
    sat  = 1'b0;
    rad  = k * k * r + (((dhi >= dlo) ? dhi - dlo : 256'd0) * c << (FB + 1));
    rad  = (rad * r) << (2 * FB);
    root = isqrt256(rad);
    ofs  = (k * r) << FB;
    root = (root >= ofs) ? root - ofs : 256'd0;
    q    = root / (r * c);
    if (q[255:32] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return q[31:0];
  endfunction

  // Expected zero-skew split for one beat under the current registers.
  function automatic split_res_t merge_split(logic [31:0] ca, logic [31:0] da,
                                             logic [31:0] cb, logic [31:0] db,
                                             logic [31:0] len);
    bit [255:0] r, c, wca, wda, wcb, wdb, wl, pos, neg, den, num, lim, q;
    split_res_t e;
    r   = (res_per_unit == 0) ? 256'd1 : 256'(res_per_unit);
    c   = (cap_per_unit == 0) ? 256'd1 : 256'(cap_per_unit);
    wca = ca; wda = da; wcb = cb; wdb = db; wl = len;
    e.dist_a = '0; e.dist_b = '0; e.sat = 1'b0; e.kase = SPLIT_WITHIN;
    pos = (wdb << (3 * FB + 1)) + ((r * wl * wcb) << (FB + 1)) + r * c * wl * wl;
    neg = wda << (3 * FB + 1);
    den = (((wca + wcb) * r) << (2 * FB + 1)) + ((r * c * wl) << (FB + 1));
    if (pos < neg) begin
      e.kase   = SPLIT_EXT_B;
      e.dist_b = stretch_len(wcb, wda, wdb, r, c, e.sat);
    end else begin
      num = (pos - neg) << FB;
      lim = den * wl;
      if (num > lim) begin
        e.kase   = SPLIT_EXT_A;
        e.dist_a = stretch_len(wca, wdb, wda, r, c, e.sat);
      end else begin
        q        = (den != 0) ? num / den : 256'd0;
        e.dist_a = q[31:0];
        e.dist_b = len - q[31:0];
      end
    end
    return e;
  endfunction

  // Queue the expected split on each input beat; track register writes.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      split_q.insert(split_q.size(),
                     merge_split(in_load_cap_a, in_delay_a, in_load_cap_b,
                                 in_delay_b, in_wire_length));
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_RES) res_per_unit <= cfg_data;
      else                      cap_per_unit <= cfg_data;
    end
  end

  // Check each result beat against the oldest expected split.
  always @(posedge clk) begin
    split_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (split_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat a=%h b=%h",
                                       out_dist_from_a, out_dist_from_b);
      end else begin
        e = split_q.pop_front();
        if (out_dist_from_a !== e.dist_a || out_dist_from_b !== e.dist_b ||
            out_split_case !== e.kase || out_saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp a=%h b=%h case=%0d sat=%b got a=%h b=%h case=%0d sat=%b",
                     e.dist_a, e.dist_b, e.kase, e.sat, out_dist_from_a,
                     out_dist_from_b, out_split_case, out_saturated);
        end
      end
    end
  end

  // Result-side ready: random stall after each beat, plus long holds on demand.
  always @(posedge clk) begin
    int stall_left, hold_left, seen_ticket;
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_left  = 0;
      hold_left   = 0;
      seen_ticket = 0;
    end else begin
      if (seen_ticket != hold_ticket) begin
        seen_ticket = hold_ticket;
        hold_left   = hold_len;
      end
      if (out_valid && out_ready)
        stall_left = zero_gaps ? 0 : $urandom_range(0, 11);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Send one beat after an idle gap; hold it until accepted.
  task automatic send_beat(logic [31:0] ca, logic [31:0] da, logic [31:0] cb,
                           logic [31:0] db, logic [31:0] len, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_load_cap_a  <= ca;
    in_delay_a     <= da;
    in_load_cap_b  <= cb;
    in_delay_b     <= db;
    in_wire_length <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int draw_gap();
    return zero_gaps ? 0 : $urandom_range(0, 11);
  endfunction

  // Mostly modest magnitudes so every split case shows up; some full range.
  function automatic logic [31:0] draw_field();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000);
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) zero_gaps = ~zero_gaps;
      send_beat(draw_field(), draw_field(), draw_field(), draw_field(), draw_field(),
                draw_gap());
    end
  endtask

  // Drop valid and wait for the pipe to empty completely.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (split_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_wire(logic [31:0] r, logic [31:0] c);
    drain_pipe();
    write_reg(CFG_RES, r);
    write_reg(CFG_CAP, c);
  endtask

  // Extremes and each split case under the current per-unit values.
  task automatic test_directed();
    int g;
    g = 0;
    send_beat(0, 0, 0, 0, 0, g);                        // zero denominator, equal delays
    send_beat(0, 32'h0005_0000, 0, 32'h0001_0000, 0, g); // zero denominator, A slower
    send_beat(0, 32'h0001_0000, 0, 32'h0005_0000, 0, g); // zero denominator, B slower
    send_beat(32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0004_0000, 1);  // midpoint
    send_beat(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 0, 32'h0002_0000, 3);
    send_beat(32'h0001_0000, 32'h00FF_0000, 32'h0001_0000, 0, 32'h0001_0000, 0); // stretch B
    send_beat(32'h0001_0000, 0, 32'h0001_0000, 32'h00FF_0000, 32'h0001_0000, 2); // stretch A
    send_beat(0, 32'hFFFF_FFFF, 0, 0, 0, 0);            // B stretch, may clip
    send_beat(0, 0, 0, 32'hFFFF_FFFF, 0, 0);            // A stretch, may clip
    send_beat('1, '1, '1, '1, '1, 5);
    send_beat('1, 0, '1, 0, '1, 0);
    send_beat(0, 0, 0, 0, '1, 0);
    send_beat('1, '1, 0, 0, 32'h0000_0001, 11);
    send_beat(0, 0, '1, '1, 32'h0000_0001, 0);
    send_beat(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0002, 32'h0000_0001, 0);
  endtask

  // Hold results off while beats keep coming so the input stalls.
  task automatic test_backpressure();
    zero_gaps = 1;
    hold_len  = 600;
    hold_ticket++;
    send_random(250);
    zero_gaps = 0;
  endtask

  // Pause the sender mid-stream until every result has returned.
  task automatic test_pause();
    send_random(40);
    drain_pipe();
    send_random(40);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_load_cap_a  <= '0;
    in_delay_a     <= '0;
    in_load_cap_b  <= '0;
    in_delay_b     <= '0;
    in_wire_length <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_RES;
    cfg_data       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_random(150);
    test_backpressure();
    test_pause();

    set_wire(32'h0000_0000, 32'h0000_0000);   // zero registers act as smallest value
    test_directed();
    send_random(100);

    set_wire(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_directed();
    send_random(100);

    set_wire(32'h0000_0001, 32'hFFFF_FFFF);
    send_random(60);

    set_wire(32'hFFFF_FFFF, 32'h0000_0001);
    send_random(60);

    set_wire($urandom, $urandom_range(1, 32'h0004_0000));
    send_random(60);

    set_wire(32'h0001_0000, 32'h0001_0000);
    send_random(30);

    drain_pipe();
    if (mismatches == 0)
      $display("[zero_skew_merge_distance] OK");
    else
      $display("[zero_skew_merge_distance] ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[zero_skew_merge_distance] ERROR");
    $finish;
  end

endmodule
